>>> rtl/xibe_pkg.sv
package xibe_pkg;

  localparam int unsigned ValueW       = 64;
  localparam int unsigned SizeW        = 3;
  localparam int unsigned LenW         = 4;
  localparam int unsigned HdrSlots     = 12;
  localparam int unsigned RemW         = 6;
  localparam int unsigned InTdataW     = 264;
  localparam int unsigned MaxOpcodeBytes = 3;

  // header slot positions
  localparam int unsigned SlotSeg   = 5;
  localparam int unsigned SlotRex   = 6;
  localparam int unsigned SlotOpc   = 7;
  localparam int unsigned SlotModrm = 10;
  localparam int unsigned SlotSib   = 11;

  // input tdata field offsets
  localparam int unsigned OffPrefix   = 0;
  localparam int unsigned OffRex      = 8;
  localparam int unsigned OffOpc      = 13;
  localparam int unsigned OffOpcN     = 37;
  localparam int unsigned OffModrm    = 39;
  localparam int unsigned OffSib      = 48;
  localparam int unsigned OffDispSize = 57;
  localparam int unsigned OffDispVal  = 60;
  localparam int unsigned OffImmSize  = 124;
  localparam int unsigned OffImmVal   = 127;
  localparam int unsigned OffImm2Size = 191;
  localparam int unsigned OffImm2Val  = 194;

  localparam logic [7:0] LegacyByte [5] = '{8'hF3, 8'hF2, 8'hF0, 8'h67, 8'h66};
  localparam logic [7:0] RexBase  = 8'h40;
  localparam logic [7:0] ByteMask = 8'hff;

  function automatic logic [LenW-1:0] size_len(input logic [SizeW-1:0] code);
    logic [LenW-1:0] len;
    unique case (code)
      3'd1:    len = 4'd1;
      3'd2:    len = 4'd2;
      3'd3:    len = 4'd4;
      3'd4:    len = 4'd6;
      3'd5:    len = 4'd8;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] seg_byte(input logic [2:0] seg);
    logic [7:0] b;
    unique case (seg)
      3'd1:    b = 8'h26;
      3'd2:    b = 8'h2E;
      3'd3:    b = 8'h36;
      3'd4:    b = 8'h64;
      3'd5:    b = 8'h65;
      3'd6:    b = 8'h3E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/xibe_vshift.sv
module xibe_vshift (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [xibe_pkg::SizeW-1:0]    size_i,
  input  logic [xibe_pkg::ValueW-1:0]   value_i,
  input  logic                          shift_i,
  output logic                          avail_o,
  output logic [7:0]                    byte_o
);

  logic [xibe_pkg::LenW-1:0]   cnt_q, cnt_d;
  logic [xibe_pkg::ValueW-1:0] val_q, val_d;

  always_comb begin
    cnt_d = cnt_q;
    val_d = val_q;
    if (load_i) begin
      cnt_d = xibe_pkg::size_len(size_i);
      val_d = value_i;
    end else if (shift_i) begin
      cnt_d = cnt_q - 1'b1;
      val_d = val_q >> 8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign avail_o = (cnt_q != '0);
  assign byte_o  = val_q[7:0] & xibe_pkg::ByteMask;

endmodule

>>> rtl/x86_instruction_byte_encoder.sv
// x86 instruction byte encoder
// slave side: one beat on s_axis carries a whole decoded instruction (fields
// packed in s_axis_tdata, see port comment). master side: one beat per
// machine-code byte on m_axis_tdata, m_axis_tlast high on the final byte.
// bytes leave in the order prefixes, segment, rex, opcode, modrm, sib,
// displacement, immediate, second immediate.
// one instruction is worked on at a time: s_axis_tready is high only while no
// bytes of the previous instruction remain to be produced.
// the instruction beat loads the byte counter, header mask and shift
// registers; the first byte is then registered in the output register.
// throughput: one byte per cycle while m_axis_tready does not stall, for
// instructions of n bytes, n from 0 to 36; an instruction with no bytes
// produces no beat. the byte rate is set by the single output register, fed
// from a header slot picker and three byte-wise shift registers.
// a stall on m_axis_tready holds the output register and the whole sequencer.
// reset clears the byte counter, header mask and output valid; nothing is
// emitted after reset until a new instruction arrives.
module x86_instruction_byte_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // prefix_code, rex_code, opcode_bytes, opcode_count, modrm_code, sib_code,
  // disp_size, disp_value, imm_size, imm_value, imm2_size, imm2_value, zero pad
  input  logic [xibe_pkg::InTdataW-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // code_byte
  output logic [7:0]                    m_axis_tdata,
  output logic                          m_axis_tlast
);

  logic [7:0]  prefix_code;
  logic [4:0]  rex_code;
  logic [23:0] opcode_bytes;
  logic [1:0]  opcode_count;
  logic [8:0]  modrm_code;
  logic [8:0]  sib_code;
  logic [xibe_pkg::SizeW-1:0]  disp_size, imm_size, imm2_size;
  logic [xibe_pkg::ValueW-1:0] disp_value, imm_value, imm2_value;

  logic [xibe_pkg::HdrSlots-1:0] mask_q, mask_d, hdr_mask_new, sel_oh;
  logic [7:0] hdr_q [xibe_pkg::HdrSlots];
  logic [7:0] hdr_new [xibe_pkg::HdrSlots];
  logic [7:0] hdr_byte;
  logic [1:0] opc_n;
  logic [xibe_pkg::RemW-1:0] rem_q, rem_d, total;
  logic       out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [7:0] out_data_q, out_data_d;
  logic       load, advance, hdr_any;
  logic       disp_av, imm_av, imm2_av;
  logic       disp_sh, imm_sh, imm2_sh;
  logic [7:0] disp_b, imm_b, imm2_b, gen_byte;

  assign prefix_code  = s_axis_tdata[xibe_pkg::OffPrefix +: 8];
  assign rex_code     = s_axis_tdata[xibe_pkg::OffRex +: 5];
  assign opcode_bytes = s_axis_tdata[xibe_pkg::OffOpc +: 24];
  assign opcode_count = s_axis_tdata[xibe_pkg::OffOpcN +: 2];
  assign modrm_code   = s_axis_tdata[xibe_pkg::OffModrm +: 9];
  assign sib_code     = s_axis_tdata[xibe_pkg::OffSib +: 9];
  assign disp_size    = s_axis_tdata[xibe_pkg::OffDispSize +: xibe_pkg::SizeW];
  assign disp_value   = s_axis_tdata[xibe_pkg::OffDispVal +: xibe_pkg::ValueW];
  assign imm_size     = s_axis_tdata[xibe_pkg::OffImmSize +: xibe_pkg::SizeW];
  assign imm_value    = s_axis_tdata[xibe_pkg::OffImmVal +: xibe_pkg::ValueW];
  assign imm2_size    = s_axis_tdata[xibe_pkg::OffImm2Size +: xibe_pkg::SizeW];
  assign imm2_value   = s_axis_tdata[xibe_pkg::OffImm2Val +: xibe_pkg::ValueW];

  assign s_axis_tready = (rem_q == '0);
  assign load          = s_axis_tvalid && s_axis_tready;
  assign advance       = (rem_q != '0) && (!out_valid_q || m_axis_tready);
  assign hdr_any       = |mask_q;

  // header slots: five legacy prefixes, segment, rex, opcodes, modrm, sib
  always_comb begin
    opc_n = (32'(opcode_count) > xibe_pkg::MaxOpcodeBytes)
          ? 2'(xibe_pkg::MaxOpcodeBytes) : opcode_count;
    for (int i = 0; i < 5; i++) begin
      hdr_new[i]      = xibe_pkg::LegacyByte[i];
      hdr_mask_new[i] = prefix_code[i];
    end
    hdr_new[xibe_pkg::SlotSeg]      = xibe_pkg::seg_byte(prefix_code[7:5]);
    hdr_mask_new[xibe_pkg::SlotSeg] = (prefix_code[7:5] != 3'd0) && (prefix_code[7:5] != 3'd7);
    hdr_new[xibe_pkg::SlotRex]      = xibe_pkg::RexBase | {4'd0, rex_code[3:0]};
    hdr_mask_new[xibe_pkg::SlotRex] = rex_code[4];
    for (int i = 0; i < 3; i++) begin
      hdr_new[xibe_pkg::SlotOpc + i]      = opcode_bytes[8*i +: 8];
      hdr_mask_new[xibe_pkg::SlotOpc + i] = (2'(i) < opc_n);
    end
    hdr_new[xibe_pkg::SlotModrm]      = modrm_code[7:0];
    hdr_mask_new[xibe_pkg::SlotModrm] = modrm_code[8];
    hdr_new[xibe_pkg::SlotSib]        = sib_code[7:0];
    hdr_mask_new[xibe_pkg::SlotSib]   = sib_code[8];
  end

  assign total = xibe_pkg::RemW'($countones(hdr_mask_new))
               + xibe_pkg::RemW'(xibe_pkg::size_len(disp_size))
               + xibe_pkg::RemW'(xibe_pkg::size_len(imm_size))
               + xibe_pkg::RemW'(xibe_pkg::size_len(imm2_size));

  // lowest pending header slot
  assign sel_oh = mask_q & ~(mask_q - 1'b1);

  always_comb begin
    hdr_byte = '0;
    for (int i = 0; i < xibe_pkg::HdrSlots; i++) begin
      hdr_byte = hdr_byte | (sel_oh[i] ? hdr_q[i] : 8'h00);
    end
  end

  assign disp_sh = advance && !hdr_any && disp_av;
  assign imm_sh  = advance && !hdr_any && !disp_av && imm_av;
  assign imm2_sh = advance && !hdr_any && !disp_av && !imm_av && imm2_av;

  always_comb begin
    priority if (hdr_any) begin
      gen_byte = hdr_byte;
    end else if (disp_av) begin
      gen_byte = disp_b;
    end else if (imm_av) begin
      gen_byte = imm_b;
    end else begin
      gen_byte = imm2_b;
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (load) begin
      mask_d = hdr_mask_new;
    end else if (advance && hdr_any) begin
      mask_d = mask_q & (mask_q - 1'b1);
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (load) begin
      rem_d = total;
    end else if (advance) begin
      rem_d = rem_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_data_d  = gen_byte;
      out_last_d  = (rem_q == xibe_pkg::RemW'(1));
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    if (load) begin
      hdr_q <= hdr_new;
    end
  end

  xibe_vshift u_disp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .size_i  (disp_size),
    .value_i (disp_value),
    .shift_i (disp_sh),
    .avail_o (disp_av),
    .byte_o  (disp_b)
  );

  xibe_vshift u_imm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .size_i  (imm_size),
    .value_i (imm_value),
    .shift_i (imm_sh),
    .avail_o (imm_av),
    .byte_o  (imm_b)
  );

  xibe_vshift u_imm2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .size_i  (imm2_size),
    .value_i (imm2_value),
    .shift_i (imm2_sh),
    .avail_o (imm2_av),
    .byte_o  (imm2_b)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> verif/tb_x86_instruction_byte_encoder.sv
module tb_x86_instruction_byte_encoder;

  // size codes for displacement and immediates
  localparam logic [2:0] SzNone  = 3'd0;
  localparam logic [2:0] SzByte  = 3'd1;
  localparam logic [2:0] SzWord  = 3'd2;
  localparam logic [2:0] SzDword = 3'd3;
  localparam logic [2:0] SzSix   = 3'd4;
  localparam logic [2:0] SzQword = 3'd5;
  localparam logic [2:0] SzBad6  = 3'd6;
  localparam logic [2:0] SzBad7  = 3'd7;

  // segment override codes
  localparam logic [2:0] SegNone   = 3'd0;
  localparam logic [2:0] SegEs     = 3'd1;
  localparam logic [2:0] SegCs     = 3'd2;
  localparam logic [2:0] SegSs     = 3'd3;
  localparam logic [2:0] SegFs     = 3'd4;
  localparam logic [2:0] SegGs     = 3'd5;
  localparam logic [2:0] SegDs     = 3'd6;
  localparam logic [2:0] SegUnused = 3'd7;

  // prefix_code bit positions
  localparam int unsigned PfxRep   = 0;
  localparam int unsigned PfxRepnz = 1;
  localparam int unsigned PfxLock  = 2;
  localparam int unsigned PfxAddr  = 3;
  localparam int unsigned PfxOpnd  = 4;

  localparam logic [7:0] LegacyPrefix [5] = '{8'hF3, 8'hF2, 8'hF0, 8'h67, 8'h66};
  localparam logic [7:0] RexHigh = 8'h40;
  localparam int unsigned LimitCycles = 3000000;

  typedef struct packed {
    logic [7:0]  prefix;
    logic [4:0]  rex;
    logic [23:0] opc;
    logic [1:0]  opc_n;
    logic [8:0]  modrm;
    logic [8:0]  sib;
    logic [2:0]  disp_sz;
    logic [63:0] disp;
    logic [2:0]  imm_sz;
    logic [63:0] imm;
    logic [2:0]  imm2_sz;
    logic [63:0] imm2;
  } instr_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } code_beat_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [xibe_pkg::InTdataW-1:0] s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [7:0]                    m_axis_tdata;
  logic                          m_axis_tlast;

  code_beat_t  pending_bytes [$];
  int unsigned items_sent  = 0;
  int unsigned empty_items = 0;
  int unsigned bytes_seen  = 0;
  int unsigned mismatches  = 0;
  bit          src_idle_en  = 1'b0;
  bit          sink_idle_en = 1'b0;
  int unsigned stall_left   = 0;

  x86_instruction_byte_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned bytes_for_size(input logic [2:0] code);
    case (code)
      SzByte:  return 1;
      SzWord:  return 2;
      SzDword: return 4;
      SzSix:   return 6;
      SzQword: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic logic [xibe_pkg::InTdataW-1:0] pack_instr(input instr_t ins);
    logic [xibe_pkg::InTdataW-1:0] d;
    d = '0;
    d[xibe_pkg::OffPrefix   +: 8]  = ins.prefix;
    d[xibe_pkg::OffRex      +: 5]  = ins.rex;
    d[xibe_pkg::OffOpc      +: 24] = ins.opc;
    d[xibe_pkg::OffOpcN     +: 2]  = ins.opc_n;
    d[xibe_pkg::OffModrm    +: 9]  = ins.modrm;
    d[xibe_pkg::OffSib      +: 9]  = ins.sib;
    d[xibe_pkg::OffDispSize +: 3]  = ins.disp_sz;
    d[xibe_pkg::OffDispVal  +: 64] = ins.disp;
    d[xibe_pkg::OffImmSize  +: 3]  = ins.imm_sz;
    d[xibe_pkg::OffImmVal   +: 64] = ins.imm;
    d[xibe_pkg::OffImm2Size +: 3]  = ins.imm2_sz;
    d[xibe_pkg::OffImm2Val  +: 64] = ins.imm2;
    return d;
  endfunction

  // machine-code bytes of one instruction, appended to pending_bytes
  function automatic int unsigned encode_bytes(input instr_t ins);
    logic [7:0]  seq [$];
    logic [2:0]  seg;
    logic [2:0]  sz [3];
    logic [63:0] val [3];
    int unsigned n_op;
    code_beat_t  b;
    for (int i = 0; i < 5; i++)
      if (ins.prefix[i]) seq = {seq, LegacyPrefix[i]};
    seg = ins.prefix[7:5];
    case (seg)
      SegEs:   seq = {seq, 8'h26};
      SegCs:   seq = {seq, 8'h2E};
      SegSs:   seq = {seq, 8'h36};
      SegFs:   seq = {seq, 8'h64};
      SegGs:   seq = {seq, 8'h65};
      SegDs:   seq = {seq, 8'h3E};
      default: ;
    endcase
    if (ins.rex[4]) seq = {seq, RexHigh | {4'b0, ins.rex[3:0]}};
    n_op = ins.opc_n;
    if (n_op > xibe_pkg::MaxOpcodeBytes) n_op = xibe_pkg::MaxOpcodeBytes;
    for (int i = 0; i < n_op; i++) seq = {seq, ins.opc[8*i +: 8]};
    if (ins.modrm[8]) seq = {seq, ins.modrm[7:0]};
    if (ins.sib[8]) seq = {seq, ins.sib[7:0]};
    sz[0] = ins.disp_sz;  val[0] = ins.disp;
    sz[1] = ins.imm_sz;   val[1] = ins.imm;
    sz[2] = ins.imm2_sz;  val[2] = ins.imm2;
    for (int f = 0; f < 3; f++)
      for (int i = 0; i < bytes_for_size(sz[f]); i++) seq = {seq, val[f][8*i +: 8]};
    for (int i = 0; i < seq.size(); i++) begin
      b.code = seq[i];
      b.last = (i == seq.size() - 1);
      pending_bytes = {pending_bytes, b};
    end
    return seq.size();
  endfunction

  task automatic send_instr(input instr_t ins);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= pack_instr(ins);
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (encode_bytes(ins) == 0) empty_items++;
    items_sent++;
  endtask

  // lowers valid and waits for every outstanding byte
  task automatic wait_all_bytes();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [2:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return SzNone;
    if (r < 72) return SzByte;
    if (r < 78) return SzWord;
    if (r < 93) return SzDword;
    if (r < 96) return SzSix;
    if (r < 99) return SzQword;
    return 3'($urandom_range(6, 7));
  endfunction

  function automatic instr_t random_instr();
    instr_t ins;
    int unsigned r;
    r = $urandom_range(0, 99);
    ins.prefix  = 8'($urandom);
    ins.rex     = 5'($urandom);
    ins.opc     = 24'($urandom);
    ins.opc_n   = 2'($urandom);
    ins.modrm   = 9'($urandom);
    ins.sib     = 9'($urandom);
    ins.disp_sz = 3'($urandom);
    ins.disp    = {$urandom, $urandom};
    ins.imm_sz  = 3'($urandom);
    ins.imm     = {$urandom, $urandom};
    ins.imm2_sz = 3'($urandom);
    ins.imm2    = {$urandom, $urandom};
    if (r < 4) begin
      // nothing present but junk in the unused bits
      ins.prefix  = 8'h00;
      ins.rex[4]  = 1'b0;
      ins.opc_n   = 2'd0;
      ins.modrm[8] = 1'b0;
      ins.sib[8]  = 1'b0;
      ins.disp_sz = SzNone;
      ins.imm_sz  = SzBad6;
      ins.imm2_sz = SzBad7;
    end else if (r >= 20) begin
      // realistic instruction shape
      for (int i = 0; i < 5; i++) ins.prefix[i] = ($urandom_range(0, 5) == 0);
      ins.prefix[7:5] = ($urandom_range(0, 4) == 0) ? 3'($urandom) : SegNone;
      ins.rex[4]   = ($urandom_range(0, 2) == 0);
      ins.opc_n    = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(2, 3)) : 2'd1;
      ins.modrm[8] = ($urandom_range(0, 9) < 7);
      ins.sib[8]   = ins.modrm[8] && ($urandom_range(0, 9) < 3);
      ins.disp_sz  = pick_size();
      ins.imm_sz   = pick_size();
      ins.imm2_sz  = ($urandom_range(0, 9) == 0) ? pick_size() : SzNone;
    end
    return ins;
  endfunction

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(1, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : byte_check
    code_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got byte %02h last %0b",
                 $time, m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata !== want.code) begin
          $display("%0t: code byte mismatch, expected %02h, got %02h",
                   $time, want.code, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last flag mismatch, expected %0b, got %0b",
                   $time, want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  task automatic test_field_extremes();
    instr_t ins;
    // nothing present
    ins = '0;
    send_instr(ins);
    // longest instruction, every field at its maximum
    ins = '1;
    ins.prefix  = {SegDs, 5'h1F};
    ins.disp_sz = SzQword;
    ins.imm_sz  = SzQword;
    ins.imm2_sz = SzQword;
    send_instr(ins);
    // each legacy prefix on its own
    for (int i = PfxRep; i <= PfxOpnd; i++) begin
      ins = '0;
      ins.prefix[i] = 1'b1;
      ins.opc_n = 2'd1;
      ins.opc   = 24'h000090;
      send_instr(ins);
    end
    // every segment code, the unused one included
    for (int s = SegEs; s <= SegUnused; s++) begin
      ins = '0;
      ins.prefix = {3'(s), 5'h00};
      ins.opc_n  = 2'd1;
      ins.opc    = 24'h00008B;
      send_instr(ins);
    end
    // payload bits set but present flags clear
    ins = '0;
    ins.rex   = 5'h0F;
    ins.modrm = 9'h0FF;
    ins.sib   = 9'h0AA;
    ins.opc   = 24'hFFFFFF;
    send_instr(ins);
    // bare rex byte, then a two-byte opcode with modrm
    ins = '0;
    ins.rex = 5'h10;
    send_instr(ins);
    ins = '0;
    ins.opc_n = 2'd2;
    ins.opc   = 24'h55AF0F;
    ins.modrm = 9'h1C3;
    send_instr(ins);
  endtask

  task automatic test_size_codes();
    instr_t ins;
    for (int c = SzByte; c <= SzBad7; c++) begin
      ins = '0;
      ins.opc_n   = 2'd1;
      ins.opc     = 24'h0000C7;
      ins.disp_sz = 3'(c);
      ins.disp    = 64'h8877665544332211;
      ins.imm_sz  = 3'(c);
      ins.imm     = 64'hF0E0D0C0B0A09080;
      ins.imm2_sz = 3'(c);
      ins.imm2    = 64'h0123456789ABCDEF;
      send_instr(ins);
    end
    // second immediate alone, its last byte closes the instruction
    ins = '0;
    ins.imm2_sz = SzDword;
    ins.imm2    = 64'h00000000DEADBEEF;
    send_instr(ins);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_instr(random_instr());
  endtask

  task automatic test_drain_pause();
    test_random_traffic(20);
    wait_all_bytes();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_size_codes();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    test_random_traffic(180);
    test_drain_pause();
    sink_idle_en = 1'b0;
    test_random_traffic(150);
    src_idle_en = 1'b0;
    test_random_traffic(100);
    wait_all_bytes();
    repeat (40) @(posedge clk_i);
    $display("sent %0d instructions (%0d encode to nothing), checked %0d code bytes",
             items_sent, empty_items, bytes_seen);
    $display("prefixes, segments, rex, opcode counts, all size codes, with and without idling");
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(LimitCycles * 8);
    $display("timeout with %0d bytes outstanding", pending_bytes.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
